// ===== hdl/kpt_pkg.sv =====
package kpt_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] SEND_INTERVAL_RST    = 32'd1000;
    localparam logic [TIME_W-1:0] RESPONSE_TIMEOUT_RST = 32'd5000;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL     = 2'd0,
        CMD_RESPONSE = 2'd1,
        CMD_RESET    = 2'd2
    } kpt_cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TIMEOUT = 1'd1;

    typedef struct packed {
        logic [TIME_W-1:0] send_interval;
        logic [TIME_W-1:0] response_timeout;
    } kpt_cfg_t;

    typedef struct packed {
        logic            send_keepalive;
        logic            send_probe;
        logic [ID_W-1:0] probe_id;
        logic            timed_out;
    } kpt_result_t;

endpackage

// ===== hdl/kpt_cfg_regs.sv =====
module kpt_cfg_regs
    import kpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output kpt_cfg_t              cfg
);

    logic [TIME_W-1:0] send_interval_reg;
    logic [TIME_W-1:0] response_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_interval_reg    <= SEND_INTERVAL_RST;
            response_timeout_reg <= RESPONSE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEND_INTERVAL:    send_interval_reg    <= cfg_data[TIME_W-1:0];
                REG_RESPONSE_TIMEOUT: response_timeout_reg <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.send_interval    = send_interval_reg;
    assign cfg.response_timeout = response_timeout_reg;

endmodule

// ===== hdl/kpt_engine.sv =====
module kpt_engine
    import kpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [CMD_W-1:0]  command,
    input  logic [TIME_W-1:0] now_time,
    input  logic [ID_W-1:0]   response_id,
    input  kpt_cfg_t          cfg,
    output kpt_result_t       result
);

    logic [ID_W-1:0]   next_probe_reg,    next_probe_next;
    logic              pending_valid_reg, pending_valid_next;
    logic [ID_W-1:0]   pending_id_reg,    pending_id_next;
    logic              response_seen_reg, response_seen_next;
    logic [TIME_W-1:0] response_time_reg, response_time_next;
    logic              tick_seen_reg,     tick_seen_next;
    logic [TIME_W-1:0] tick_time_reg,     tick_time_next;

    logic [TIME_W-1:0] since_response;
    logic [TIME_W-1:0] since_tick;
    logic              timeout_hit;
    logic              interval_open;

    assign since_response = now_time - response_time_reg;
    assign since_tick     = now_time - tick_time_reg;
    assign timeout_hit    = response_seen_reg && (since_response > cfg.response_timeout);
    assign interval_open  = !(tick_seen_reg && (since_tick < cfg.send_interval));

    always_comb
    begin
        next_probe_next    = next_probe_reg;
        pending_valid_next = pending_valid_reg;
        pending_id_next    = pending_id_reg;
        response_seen_next = response_seen_reg;
        response_time_next = response_time_reg;
        tick_seen_next     = tick_seen_reg;
        tick_time_next     = tick_time_reg;
        result             = '0;

        case (command)
            CMD_POLL:
            begin
                if (timeout_hit)
                begin
                    result.timed_out   = 1'b1;
                    next_probe_next    = '0;
                    pending_valid_next = 1'b0;
                    pending_id_next    = '0;
                    response_seen_next = 1'b0;
                    response_time_next = '0;
                    tick_seen_next     = 1'b0;
                    tick_time_next     = '0;
                end
                else if (interval_open)
                begin
                    result.send_keepalive = 1'b1;
                    result.send_probe     = 1'b1;
                    result.probe_id       = next_probe_reg;
                    tick_seen_next        = 1'b1;
                    tick_time_next        = now_time;
                    pending_valid_next    = 1'b1;
                    pending_id_next       = next_probe_reg;
                    next_probe_next       = next_probe_reg + 1'b1;
                    if (!response_seen_reg)
                    begin
                        response_seen_next = 1'b1;
                        response_time_next = now_time;
                    end
                end
            end
            CMD_RESPONSE:
            begin
                if (pending_valid_reg && (pending_id_reg == response_id))
                begin
                    pending_valid_next = 1'b0;
                    response_seen_next = 1'b1;
                    response_time_next = now_time;
                end
            end
            CMD_RESET:
            begin
                next_probe_next    = '0;
                pending_valid_next = 1'b0;
                pending_id_next    = '0;
                response_seen_next = 1'b0;
                response_time_next = '0;
                tick_seen_next     = 1'b0;
                tick_time_next     = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_probe_reg    <= '0;
            pending_valid_reg <= 1'b0;
            pending_id_reg    <= '0;
            response_seen_reg <= 1'b0;
            response_time_reg <= '0;
            tick_seen_reg     <= 1'b0;
            tick_time_reg     <= '0;
        end
        else if (fire)
        begin
            next_probe_reg    <= next_probe_next;
            pending_valid_reg <= pending_valid_next;
            pending_id_reg    <= pending_id_next;
            response_seen_reg <= response_seen_next;
            response_time_reg <= response_time_next;
            tick_seen_reg     <= tick_seen_next;
            tick_time_reg     <= tick_time_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pending_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        pending_valid_reg |-> (tick_seen_reg && response_seen_reg))
        else $error("pending probe without tick/response record");

    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.timed_out) |=>
            (!pending_valid_reg && !response_seen_reg && !tick_seen_reg
             && next_probe_reg == '0))
        else $error("timeout did not clear state");

    a_probe_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.send_probe) |=>
            (next_probe_reg == $past(next_probe_reg) + 1'b1
             && pending_id_reg == $past(next_probe_reg) && pending_valid_reg))
        else $error("probe id did not advance");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(next_probe_reg) && $stable(pending_valid_reg)
                   && $stable(response_time_reg) && $stable(tick_time_reg)))
        else $error("state changed without a transfer");
`endif

endmodule

// ===== hdl/keepalive_probe_timeout_unit.sv =====
// A transferred input goes to the input register, then its result to the result register.
// One item per cycle unless out_ready stalls; state update is a single compare/subtract pass.
// Input and result registers decouple the two channels, so a new item is taken into
// an empty input register while a result waits for out_ready.
// Reset (rst_n, async, active low): state cleared, send_interval=1000, response_timeout=5000.
module keepalive_probe_timeout_unit
    import kpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [TIME_W-1:0]     now_time,
    input  logic [ID_W-1:0]       response_id,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  send_keepalive,
    output logic                  send_probe,
    output logic [ID_W-1:0]       probe_id,
    output logic                  timed_out
);

    kpt_cfg_t          cfg;
    kpt_result_t       result;

    logic              in_valid_reg;
    logic [CMD_W-1:0]  command_reg;
    logic [TIME_W-1:0] now_time_reg;
    logic [ID_W-1:0]   response_id_reg;

    logic              out_valid_reg;
    kpt_result_t       result_reg;

    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    kpt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kpt_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .command     (command_reg),
        .now_time    (now_time_reg),
        .response_id (response_id_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            command_reg     <= command;
            now_time_reg    <= now_time;
            response_id_reg <= response_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign send_keepalive = result_reg.send_keepalive;
    assign send_probe     = result_reg.send_probe;
    assign probe_id       = result_reg.probe_id;
    assign timed_out      = result_reg.timed_out;

endmodule
